// ===== hdl/gbu_pkg.sv =====
// Package: microcode word layout, control/status structs and UTF-8 helpers.
`default_nettype none

package gbu_pkg;

    localparam int UPC_W = 4;

    // Microprogram step addresses
    localparam logic [UPC_W-1:0] S_IDLE  = 4'd0;
    localparam logic [UPC_W-1:0] S_INIT  = 4'd1;
    localparam logic [UPC_W-1:0] S_PROBE = 4'd2;
    localparam logic [UPC_W-1:0] S_CMP   = 4'd3;
    localparam logic [UPC_W-1:0] S_HIT   = 4'd4;
    localparam logic [UPC_W-1:0] S_MISS  = 4'd5;
    localparam logic [UPC_W-1:0] S_EMIT0 = 4'd6;
    localparam logic [UPC_W-1:0] S_EMIT1 = 4'd7;
    localparam logic [UPC_W-1:0] S_EMIT2 = 4'd8;

    localparam logic [7:0]  ASCII_LIMIT = 8'h80;
    localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
    localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_READ,
        OP_STEP,
        OP_HIT,
        OP_MISS,
        OP_EMIT
    } t_uop;

    typedef enum logic [1:0] {
        W_NONE,
        W_IN,
        W_OUT
    } t_wait;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_ZERO,
        J_PROBE,
        J_EMIT
    } t_jump;

    typedef enum logic [1:0] {
        DISP_STAY,
        DISP_SEARCH,
        DISP_RAW
    } t_disp;

    typedef struct packed {
        logic             ready;
        t_wait            wt;
        t_uop             op;
        logic [1:0]       sel;
        t_jump            jmp;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic       ready;
        logic       fire;
        t_uop       op;
        logic [1:0] sel;
    } t_ctl;

    typedef struct packed {
        logic  accept;
        t_disp disp;
        logic  n_zero;
        logic  hit;
        logic  last_probe;
        logic  last_byte;
        logic  out_free;
    } t_stat;

    // Microprogram ROM
    function automatic t_uword ucode(input logic [UPC_W-1:0] pc);
        t_uword w;
        w = '{ready: 1'b0, wt: W_NONE, op: OP_NONE, sel: 2'd0,
              jmp: J_NEXT, target: S_IDLE};
        case (pc)
            S_IDLE: begin
                w.ready = 1'b1;
                w.wt    = W_IN;
                w.jmp   = J_DISPATCH;
            end
            S_INIT: begin
                w.op     = OP_INIT;
                w.jmp    = J_ZERO;
                w.target = S_MISS;
            end
            S_PROBE: begin
                w.op = OP_READ;
            end
            S_CMP: begin
                w.op     = OP_STEP;
                w.jmp    = J_PROBE;
                w.target = S_PROBE;
            end
            S_HIT: begin
                w.op     = OP_HIT;
                w.jmp    = J_GOTO;
                w.target = S_EMIT0;
            end
            S_MISS: begin
                w.op = OP_MISS;
            end
            S_EMIT0: begin
                w.op     = OP_EMIT;
                w.wt     = W_OUT;
                w.sel    = 2'd0;
                w.jmp    = J_EMIT;
                w.target = S_IDLE;
            end
            S_EMIT1: begin
                w.op     = OP_EMIT;
                w.wt     = W_OUT;
                w.sel    = 2'd1;
                w.jmp    = J_EMIT;
                w.target = S_IDLE;
            end
            S_EMIT2: begin
                w.op     = OP_EMIT;
                w.wt     = W_OUT;
                w.sel    = 2'd2;
                w.jmp    = J_GOTO;
                w.target = S_IDLE;
            end
            default: begin
                w.jmp    = J_GOTO;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    // Number of UTF-8 bytes for a code point, minus one
    function automatic logic [1:0] utf8_last(input logic [15:0] cp);
        logic [1:0] r;
        if (cp <= ONE_BYTE_MAX) begin
            r = 2'd0;
        end else if (cp <= TWO_BYTE_MAX) begin
            r = 2'd1;
        end else begin
            r = 2'd2;
        end
        return r;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [15:0] cp, input logic [1:0] sel);
        logic [7:0] b;
        logic [1:0] last;
        last = utf8_last(cp);
        b = 8'h00;
        case (last)
            2'd0: b = {1'b0, cp[6:0]};
            2'd1: begin
                if (sel == 2'd0) begin
                    b = 8'hC0 | {3'b000, cp[10:6]};
                end else begin
                    b = 8'h80 | {2'b00, cp[5:0]};
                end
            end
            default: begin
                case (sel)
                    2'd0:    b = 8'hE0 | {4'h0, cp[15:12]};
                    2'd1:    b = 8'h80 | {2'b00, cp[11:6]};
                    default: b = 8'h80 | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gbu_if.sv =====
// Channel interfaces: input transactions and output byte transactions.
`default_nettype none

interface gbu_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [14:0] entry_index;
    logic [15:0] entry_key;
    logic [15:0] entry_value;
    logic [7:0]  text_byte;
    logic        end_of_text;

    modport source (output valid, action, entry_index, entry_key, entry_value,
                    text_byte, end_of_text, input ready);
    modport sink   (input valid, action, entry_index, entry_key, entry_value,
                    text_byte, end_of_text, output ready);
endinterface

interface gbu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       code_missing;

    modport source (output valid, out_byte, last_of_run, code_missing, input ready);
    modport sink   (input valid, out_byte, last_of_run, code_missing, output ready);
endinterface

`default_nettype wire

// ===== hdl/gbu_seq.sv =====
// Microcode sequencer: step counter, control ROM and jump logic.
`default_nettype none

module gbu_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gbu_pkg::t_stat i_stat,
    output gbu_pkg::t_ctl      o_ctl
);
    import gbu_pkg::*;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           uw;
    logic             stall;

    assign uw    = ucode(r_upc);
    assign stall = ((uw.wt == W_IN) && !i_stat.accept) ||
                   ((uw.wt == W_OUT) && !i_stat.out_free);

    always_comb begin
        n_upc = r_upc;
        if (!stall) begin
            case (uw.jmp)
                J_NEXT:  n_upc = r_upc + 1'b1;
                J_GOTO:  n_upc = uw.target;
                J_DISPATCH: begin
                    case (i_stat.disp)
                        DISP_SEARCH: n_upc = S_INIT;
                        DISP_RAW:    n_upc = S_EMIT0;
                        default:     n_upc = S_IDLE;
                    endcase
                end
                J_ZERO:  n_upc = i_stat.n_zero ? uw.target : r_upc + 1'b1;
                J_PROBE: begin
                    if (i_stat.hit) begin
                        n_upc = S_HIT;
                    end else if (i_stat.last_probe) begin
                        n_upc = S_MISS;
                    end else begin
                        n_upc = uw.target;
                    end
                end
                J_EMIT:  n_upc = i_stat.last_byte ? uw.target : r_upc + 1'b1;
                default: n_upc = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctl.ready = uw.ready;
    assign o_ctl.fire  = !stall;
    assign o_ctl.op    = uw.op;
    assign o_ctl.sel   = uw.sel;

endmodule

`default_nettype wire

// ===== hdl/gbu_dp.sv =====
// Datapath: code table memory, search registers, lead-byte state and output register.
`default_nettype none

module gbu_dp #(
    parameter int TABLE_DEPTH  = 32768,
    parameter int SEARCH_STEPS = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [15:0]   i_entry_count,
    input  wire gbu_pkg::t_ctl i_ctl,
    output gbu_pkg::t_stat     o_stat,
    gbu_in_if.sink             i_in,
    gbu_out_if.source          o_out
);
    import gbu_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = $clog2(SEARCH_STEPS + 1);

    logic [31:0]   r_table [TABLE_DEPTH];
    logic [31:0]   r_rd_word;

    logic          r_pending;
    logic [7:0]    r_lead;
    logic [15:0]   r_code;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_mid;
    logic [SW-1:0] r_step;
    logic [15:0]   r_cp;
    logic          r_miss;
    logic          r_raw;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    logic          r_out_miss;

    logic          accept;
    logic          fire_op;
    t_disp         disp;
    logic [CW-1:0] diff;
    logic [CW-1:0] mid;
    logic [CW-1:0] count_clamp;
    logic [31:0]   idx_ext;
    logic          idx_ok;
    logic          hit;
    logic [1:0]    last_sel;
    logic          out_free;
    logic [7:0]    emit_byte;

    assign accept  = i_in.valid && i_ctl.ready;
    assign fire_op = i_ctl.fire;
    assign idx_ext = 32'(i_in.entry_index);
    assign idx_ok  = idx_ext < 32'(TABLE_DEPTH);

    always_comb begin
        if (!i_in.action) begin
            disp = DISP_STAY;
        end else if (r_pending) begin
            disp = DISP_SEARCH;
        end else if ((i_in.text_byte < ASCII_LIMIT) || i_in.end_of_text) begin
            disp = DISP_RAW;
        end else begin
            disp = DISP_STAY;
        end
    end

    assign count_clamp = (32'(i_entry_count) > 32'(TABLE_DEPTH)) ?
                         CW'(TABLE_DEPTH) : CW'(i_entry_count);
    assign diff = r_hi - r_lo;
    assign mid  = r_lo + (diff >> 1);
    assign hit  = (r_rd_word[31:16] == r_code);

    assign last_sel  = r_raw ? 2'd0 : utf8_last(r_cp);
    assign emit_byte = r_raw ? r_cp[7:0] : utf8_byte(r_cp, i_ctl.sel);
    assign out_free  = !r_out_valid || o_out.ready;

    // Table port: write on table transactions, registered read per probe
    always_ff @(posedge i_clk) begin
        if (accept && !i_in.action && idx_ok) begin
            r_table[idx_ext[AW-1:0]] <= {i_in.entry_key, i_in.entry_value};
        end
        if (fire_op && (i_ctl.op == OP_READ)) begin
            r_rd_word <= r_table[mid[AW-1:0]];
        end
    end

    // Lead byte state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_lead    <= 8'h00;
        end else if (accept && i_in.action) begin
            if (r_pending) begin
                r_pending <= 1'b0;
                r_lead    <= 8'h00;
            end else if ((i_in.text_byte >= ASCII_LIMIT) && !i_in.end_of_text) begin
                r_pending <= 1'b1;
                r_lead    <= i_in.text_byte;
            end
        end
    end

    // Search and code point registers
    always_ff @(posedge i_clk) begin
        if (accept && (disp == DISP_SEARCH)) begin
            r_code <= {r_lead, i_in.text_byte};
            r_raw  <= 1'b0;
        end
        if (accept && (disp == DISP_RAW)) begin
            r_cp   <= {8'h00, i_in.text_byte};
            r_raw  <= 1'b1;
            r_miss <= 1'b0;
        end
        if (fire_op) begin
            case (i_ctl.op)
                OP_INIT: begin
                    r_lo   <= '0;
                    r_hi   <= count_clamp;
                    r_step <= '0;
                end
                OP_READ: r_mid <= mid;
                OP_STEP: begin
                    if (!hit) begin
                        if (r_code > r_rd_word[31:16]) begin
                            r_lo <= r_mid;
                        end else begin
                            r_hi <= r_mid;
                        end
                        r_step <= r_step + 1'b1;
                    end
                end
                OP_HIT: begin
                    r_cp   <= r_rd_word[15:0];
                    r_miss <= 1'b0;
                end
                OP_MISS: begin
                    r_cp   <= 16'h0000;
                    r_miss <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_op && (i_ctl.op == OP_EMIT)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_op && (i_ctl.op == OP_EMIT)) begin
            r_out_byte <= emit_byte;
            r_out_last <= (i_ctl.sel == last_sel);
            r_out_miss <= r_miss;
        end
    end

    assign i_in.ready         = i_ctl.ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.last_of_run  = r_out_last;
    assign o_out.code_missing = r_out_miss;

    assign o_stat.accept     = accept;
    assign o_stat.disp       = disp;
    assign o_stat.n_zero     = (i_entry_count == 16'h0000);
    assign o_stat.hit        = hit;
    assign o_stat.last_probe = (r_step == SW'(SEARCH_STEPS - 1));
    assign o_stat.last_byte  = (i_ctl.sel == last_sel);
    assign o_stat.out_free   = out_free;

endmodule

`default_nettype wire

// ===== hdl/gb2312_to_utf8_transcoder.sv =====
// Top level: GB2312 to UTF-8 transcoder with a loadable sorted code table.
`default_nettype none

// Channel   Dir  Handshake        Payload
// i_in      in   valid/ready      action, entry_index, entry_key, entry_value,
//                                 text_byte, end_of_text
// o_out     out  valid/ready      out_byte, last_of_run, code_missing
// i_cfg_*   in   write enable     entry_count (16 bit)
//
// Steps: a table write or a held lead byte is only accepted in idle; a raw byte
// is accepted, then emitted; a two-byte code is accepted, then init, then up to
// SEARCH_STEPS probes (registered read, key compare), hit or miss, 1 to 3 emits.
// Reset clears the step counter, lead-byte state and output valid; the table
// holds no valid bits and is undefined until written.
// A stalled output holds the emit step; no new transaction is taken until the
// last byte of the current one is in the output register.

module gb2312_to_utf8_transcoder #(
    parameter int TABLE_DEPTH  = 32768,
    parameter int SEARCH_STEPS = 17
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    gbu_in_if.sink           i_in,
    gbu_out_if.source        o_out
);
    import gbu_pkg::*;

    logic [15:0] r_entry_count;
    t_ctl        ctl;
    t_stat       stat;

    // entry_count register; the user must write it only while idle, not enforced here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= 16'h0000;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_data;
        end
    end

    // Microprogram: idle/dispatch, init, probe/compare loop, hit or miss, emit
    gbu_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    // Datapath: table memory, binary search registers, UTF-8 byte builder
    gbu_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .SEARCH_STEPS (SEARCH_STEPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_count (r_entry_count),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .i_in          (i_in),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire
